/* rtl/websocket_frame_deframer_macros.svh */
// Assertion helpers for the deframer. Clock is i_clk, reset is i_rst_n.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define WSDF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while in reset.
`define WSDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

/* rtl/wsdf_pkg.sv */
`timescale 1ns / 1ps
package wsdf_pkg;

    localparam logic [6:0] LEN7_MASK = 7'h7F;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] HDR_CNT_EXT16 = 4'd2;
    localparam logic [3:0] HDR_CNT_EXT64 = 4'd8;
    localparam logic [3:0] HDR_CNT_KEY   = 4'd4;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    typedef struct packed {
        logic        is_header;
        logic        final_flag;
        logic [6:0]  op_field;
        logic        was_masked;
        logic [63:0] frame_length;
        logic [7:0]  payload_byte;
        logic        frame_end;
    } t_result;

endpackage

/* rtl/wsdf_in_reg.sv */
`timescale 1ns / 1ps
module wsdf_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_stream_byte,
    input  logic       i_advance,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    import wsdf_pkg::*;

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       w_load;

    // Slot is free when empty or when its byte moves on this cycle.
    assign w_load  = !r_valid || i_advance;
    assign o_stall = !w_load;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_byte <= i_stream_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

/* rtl/wsdf_parser.sv */
`timescale 1ns / 1ps
module wsdf_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output wsdf_pkg::t_result o_res,
    output wsdf_pkg::t_phase  o_phase
);
    import wsdf_pkg::*;

    t_phase      r_phase,  n_phase;
    logic        r_fin,    n_fin;
    logic [6:0]  r_op,     n_op;
    logic        r_mask,   n_mask;
    logic [63:0] r_len,    n_len;
    logic [63:0] r_rem,    n_rem;
    logic [3:0]  r_cnt,    n_cnt;
    logic [31:0] r_key,    n_key;
    logic [1:0]  r_midx,   n_midx;

    logic        w_len_done;
    logic        w_emit;
    logic        w_end;
    logic [7:0]  w_key_byte;
    logic [6:0]  w_len7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_fin   <= 1'b0;
            r_op    <= '0;
            r_mask  <= 1'b0;
            r_len   <= '0;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_key   <= '0;
            r_midx  <= '0;
        end else begin
            r_phase <= n_phase;
            r_fin   <= n_fin;
            r_op    <= n_op;
            r_mask  <= n_mask;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_cnt   <= n_cnt;
            r_key   <= n_key;
            r_midx  <= n_midx;
        end
    end

    assign w_len7 = i_byte[6:0] & LEN7_MASK;

    always_comb begin
        case (r_midx)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_fin       = r_fin;
        n_op        = r_op;
        n_mask      = r_mask;
        n_len       = r_len;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_key       = r_key;
        n_midx      = r_midx;
        w_len_done  = 1'b0;
        w_emit      = 1'b0;
        w_end       = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_step) begin
            case (r_phase)
                PH_SECOND: begin
                    n_mask = i_byte[7];
                    n_len  = '0;
                    if (w_len7 == LEN_EXT16) begin
                        n_cnt   = HDR_CNT_EXT16;
                        n_phase = PH_EXTLEN;
                    end else if (w_len7 == LEN_EXT64) begin
                        n_cnt   = HDR_CNT_EXT64;
                        n_phase = PH_EXTLEN;
                    end else begin
                        n_len      = {57'd0, w_len7};
                        w_len_done = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    n_len = {r_len[55:0], i_byte};
                    n_cnt = r_cnt - 4'd1;
                    if (n_cnt == 4'd0) begin
                        w_len_done = 1'b1;
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], i_byte};
                    n_cnt = r_cnt - 4'd1;
                    if (n_cnt == 4'd0) begin
                        w_emit = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_rem  = r_rem - 64'd1;
                    n_midx = r_midx + 2'd1;
                    w_end  = (n_rem == 64'd0);
                    if (w_end) begin
                        n_phase = PH_FIRST;
                    end
                    o_res_valid        = 1'b1;
                    o_res.is_header    = 1'b0;
                    o_res.payload_byte = i_byte ^ w_key_byte;
                    o_res.frame_end    = w_end;
                end
                default: begin
                    // first header byte; unused phase codes land here too
                    n_fin   = i_byte[7];
                    n_op    = i_byte[6:0] & LEN7_MASK;
                    n_mask  = 1'b0;
                    n_len   = '0;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_key   = '0;
                    n_midx  = '0;
                    n_phase = PH_SECOND;
                end
            endcase

            // length known: key bytes next, or the header is complete
            if (w_len_done) begin
                if (n_mask) begin
                    n_cnt   = HDR_CNT_KEY;
                    n_phase = PH_MASK;
                end else begin
                    w_emit = 1'b1;
                end
            end

            if (w_emit) begin
                n_rem              = n_len;
                n_midx             = '0;
                n_phase            = (n_len != 64'd0) ? PH_PAYLOAD : PH_FIRST;
                o_res_valid        = 1'b1;
                o_res.is_header    = 1'b1;
                o_res.payload_byte = '0;
                o_res.frame_end    = (n_len == 64'd0);
            end

            o_res.final_flag   = n_fin;
            o_res.op_field     = n_op;
            o_res.was_masked   = n_mask;
            o_res.frame_length = n_len;
        end
    end

    assign o_phase = r_phase;

endmodule

/* rtl/wsdf_out_reg.sv */
`timescale 1ns / 1ps
module wsdf_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_res_valid,
    input  wsdf_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_valid,
    output wsdf_pkg::t_result o_res
);
    import wsdf_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // An advance only happens when this slot is empty or being drained.
    always_comb begin
        if (i_advance) begin
            n_valid = i_res_valid;
        end else begin
            n_valid = r_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* rtl/websocket_frame_deframer.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  ----------------------------------------
// input     in         i_valid / o_stall    i_stream_byte
// result    out        o_valid / i_stall    o_is_header .. o_frame_end (7 fields)
//
// One byte per clock sustained while i_stall is low; a byte passes through the
// input register, then parser logic into the result register. The 64-bit
// remaining-count decrement and compare is the longest path.
// Synchronous active-low reset clears both valid flags and all parser state.
// o_stall rises only when the input register is full and the result register
// is held by i_stall; a waiting result does not block the next byte entering.
`include "websocket_frame_deframer_macros.svh"
module websocket_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_header,
    output logic        o_final_flag,
    output logic [6:0]  o_op_field,
    output logic        o_was_masked,
    output logic [63:0] o_frame_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_frame_end
);
    import wsdf_pkg::*;

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_advance;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out_res;
    t_phase     w_phase;

    // A buffered byte is parsed when the result slot is free or draining.
    assign w_advance = w_in_valid && (!o_valid || !i_stall);

    wsdf_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_stream_byte (i_stream_byte),
        .i_advance     (w_advance),
        .o_stall       (o_stall),
        .o_valid       (w_in_valid),
        .o_byte        (w_in_byte)
    );

    // Frame state machine; updates its state only on a parsed byte.
    wsdf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_byte      (w_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_phase     (w_phase)
    );

    wsdf_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (w_out_res)
    );

    assign o_is_header    = w_out_res.is_header;
    assign o_final_flag   = w_out_res.final_flag;
    assign o_op_field     = w_out_res.op_field;
    assign o_was_masked   = w_out_res.was_masked;
    assign o_frame_length = w_out_res.frame_length;
    assign o_payload_byte = w_out_res.payload_byte;
    assign o_frame_end    = w_out_res.frame_end;

    // a produced result always lands in the result register
    `WSDF_ASSERT_NEXT(a_res_lands, w_advance && w_res_valid, o_valid)
    // payload results only come from the payload phase
    `WSDF_ASSERT_IMP(a_payload_phase, w_advance && w_res_valid && !w_res.is_header, w_phase == PH_PAYLOAD)
    // the end of a frame returns the parser to the first header byte
    `WSDF_ASSERT_NEXT(a_end_restarts, w_advance && w_res_valid && w_res.frame_end, w_phase == PH_FIRST)
    // a byte held in the input register is not dropped
    `WSDF_ASSERT_NEXT(a_in_holds, w_in_valid && !w_advance, w_in_valid)

endmodule

/* tb/sv/wsdf_frame_checker.sv */
`timescale 1ns / 1ps
module wsdf_frame_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [7:0]        i_stream_byte,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  wsdf_pkg::t_result i_result,
    output int                o_mismatches,
    output int                o_pending
);
    import wsdf_pkg::*;

    // shadow parser state
    t_phase      cur_phase;
    logic        hdr_fin;
    logic [6:0]  hdr_op;
    logic        key_on;
    logic [63:0] len_acc;
    logic [63:0] left_count;
    logic [3:0]  hdr_left;
    logic [31:0] key_word;
    logic [1:0]  key_pos;

    t_result results_due[$];
    int      errors = 0;

    function automatic t_result make_result(input logic hdr, input logic [7:0] pbyte,
                                            input logic last);
        t_result r;
        r.is_header    = hdr;
        r.final_flag   = hdr_fin;
        r.op_field     = hdr_op;
        r.was_masked   = key_on;
        r.frame_length = len_acc;
        r.payload_byte = pbyte;
        r.frame_end    = last;
        return r;
    endfunction

    function automatic string describe(input t_result r);
        return $sformatf("hdr=%0b fin=%0b op=%h mask=%0b len=%h byte=%h end=%0b",
                         r.is_header, r.final_flag, r.op_field, r.was_masked,
                         r.frame_length, r.payload_byte, r.frame_end);
    endfunction

    task automatic emit_header();
        left_count = len_acc;
        key_pos    = '0;
        cur_phase  = (len_acc != 0) ? PH_PAYLOAD : PH_FIRST;
        results_due.push_back(make_result(1'b1, 8'h00, len_acc == 0));
    endtask

    task automatic length_complete();
        if (key_on) begin
            hdr_left  = HDR_CNT_KEY;
            cur_phase = PH_MASK;
        end else begin
            emit_header();
        end
    endtask

    task automatic take_byte(input logic [7:0] b);
        logic [7:0] key_b;
        case (cur_phase)
            PH_SECOND: begin
                key_on  = b[7];
                len_acc = '0;
                if ((b & LEN7_MASK) == LEN_EXT16) begin
                    hdr_left  = HDR_CNT_EXT16;
                    cur_phase = PH_EXTLEN;
                end else if ((b & LEN7_MASK) == LEN_EXT64) begin
                    hdr_left  = HDR_CNT_EXT64;
                    cur_phase = PH_EXTLEN;
                end else begin
                    len_acc = 64'(b[6:0]);
                    length_complete();
                end
            end
            PH_EXTLEN: begin
                len_acc  = {len_acc[55:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 0)
                    length_complete();
            end
            PH_MASK: begin
                key_word = {key_word[23:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 0)
                    emit_header();
            end
            PH_PAYLOAD: begin
                key_b      = key_word[8 * (3 - key_pos) +: 8];
                left_count = left_count - 64'd1;
                key_pos    = key_pos + 2'd1;
                if (left_count == 0)
                    cur_phase = PH_FIRST;
                results_due.push_back(make_result(1'b0, b ^ key_b, left_count == 0));
            end
            default: begin
                // first header byte; unused phase codes land here too
                hdr_fin    = b[7];
                hdr_op     = b[6:0];
                key_on     = 1'b0;
                len_acc    = '0;
                left_count = '0;
                hdr_left   = '0;
                key_word   = '0;
                key_pos    = '0;
                cur_phase  = PH_SECOND;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cur_phase  = PH_FIRST;
            hdr_fin    = 1'b0;
            hdr_op     = '0;
            key_on     = 1'b0;
            len_acc    = '0;
            left_count = '0;
            hdr_left   = '0;
            key_word   = '0;
            key_pos    = '0;
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("unexpected result: %s", describe(i_result));
                end else begin
                    want = results_due.pop_front();
                    if (i_result !== want) begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("mismatch\n  exp %s\n  got %s",
                                     describe(want), describe(i_result));
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                take_byte(i_stream_byte);
        end
        o_mismatches <= errors;
        o_pending    <= results_due.size();
    end

endmodule

/* tb/sv/tb_websocket_frame_deframer.sv */
`timescale 1ns / 1ps
module tb_websocket_frame_deframer;
    import wsdf_pkg::*;

    // Cycles with no transfer on either channel before the run is declared hung.
    // Worst honest gap is a long header (14 bytes) under random input idling,
    // or a result held by a stretch of receiver stalls; both are far below this.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 1600;
    localparam int IDLE_PCT       = 19;
    // Settle time after the last expected result.
    localparam int DRAIN_CYCLES   = 8;

    typedef enum int {LK_SHORT, LK_EXT16, LK_EXT64} t_len_kind;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_stream_byte = 8'h00;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_is_header;
    logic        o_final_flag;
    logic [6:0]  o_op_field;
    logic        o_was_masked;
    logic [63:0] o_frame_length;
    logic [7:0]  o_payload_byte;
    logic        o_frame_end;

    // When set, neither side idles: gives a stretch at full rate.
    logic        calm          = 1'b0;
    int          bytes_sent    = 0;
    int          idle_cycles   = 0;
    int          mismatches;
    int          pending;

    websocket_frame_deframer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_stream_byte  (i_stream_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_is_header    (o_is_header),
        .o_final_flag   (o_final_flag),
        .o_op_field     (o_op_field),
        .o_was_masked   (o_was_masked),
        .o_frame_length (o_frame_length),
        .o_payload_byte (o_payload_byte),
        .o_frame_end    (o_frame_end)
    );

    // Checker sits beside the DUT: it sees both channels, runs its own parser
    // and reports mismatch and outstanding-result counts back to us.
    wsdf_frame_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_stream_byte (i_stream_byte),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_result      ({o_is_header, o_final_flag, o_op_field, o_was_masked,
                         o_frame_length, o_payload_byte, o_frame_end}),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver back-pressure: random stalls, none while calm.
    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Watchdog: any cycle without a transfer on either side counts toward the limit.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // One byte transfer. Random idle cycles go in front; valid then stays high
    // until the byte is taken. Valid is left high on return so back-to-back
    // bytes never drop it in between.
    task automatic send_byte(input logic [7:0] b);
        while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        bytes_sent = bytes_sent + 1;
    endtask

    // A whole frame: first byte, length byte (plus extension), optional key,
    // then n_data payload bytes. n_data below the coded length leaves the
    // frame open, which the deframer simply waits on.
    task automatic send_frame(input logic [7:0] head0, input logic masked,
                              input t_len_kind kind, input logic [63:0] len,
                              input int n_data);
        logic [31:0] key;
        key = $urandom;
        send_byte(head0);
        case (kind)
            LK_EXT16: begin
                send_byte({masked, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            LK_EXT64: begin
                send_byte({masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8 * i +: 8]);
            end
            default: begin
                send_byte({masked, len[6:0]});
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                send_byte(key[8 * i +: 8]);
        for (int i = 0; i < n_data; i++)
            send_byte(8'($urandom));
    endtask

    initial begin
        int          pick;
        t_len_kind   kind;
        logic [63:0] len;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty frame with every header bit low, masked single byte
        // with FIN and all op bits set, non-minimal 16-bit and 64-bit lengths.
        send_frame(8'h00, 1'b0, LK_SHORT, 64'd0, 0);
        send_frame(8'hFF, 1'b1, LK_SHORT, 64'd1, 1);
        send_frame(8'h81, 1'b0, LK_EXT16, 64'd2, 2);
        send_frame(8'h02, 1'b0, LK_EXT64, 64'd1, 1);

        // Random well-formed frames, mostly short, with a full-rate stretch.
        while (bytes_sent < ITEM_TARGET) begin
            calm <= (bytes_sent >= 700) && (bytes_sent < 1000);
            pick = $urandom_range(99);
            kind = LK_SHORT;
            if (pick < 10) begin
                len = 64'd0;
            end else if (pick < 60) begin
                len = 64'($urandom_range(20, 1));
            end else if (pick < 70) begin
                len = 64'($urandom_range(125, 100));
            end else if (pick < 85) begin
                kind = LK_EXT16;
                len  = 64'($urandom_range(300, 0));
            end else begin
                kind = LK_EXT64;
                len  = 64'($urandom_range(40, 0));
            end
            send_frame(8'($urandom), 1'($urandom), kind, len, int'(len));
        end

        // Huge 64-bit length, top bit set, taken as is; only a few payload bytes
        // are sent and the frame is left open.
        calm <= 1'b0;
        send_frame(8'($urandom), 1'b1, LK_EXT64, '1, 12);
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/wsdf_pkg.sv
rtl/wsdf_in_reg.sv
rtl/wsdf_parser.sv
rtl/wsdf_out_reg.sv
rtl/websocket_frame_deframer.sv
tb/sv/wsdf_frame_checker.sv
tb/sv/tb_websocket_frame_deframer.sv
